@@ sv/gmcp_pkg.sv @@
// ----------------------------------------------------------------------------
// gmcp_pkg: shared definitions for the grid minimum-cost path core
// Widths, register indexes, the default row-buffer length and the row-buffer
// write request carried from the top level into the cell chain.
// ----------------------------------------------------------------------------
package gmcp_pkg;

  // Field widths.
  localparam int COST_W = 16;
  localparam int SUM_W  = 25;
  localparam int POS_W  = 8;

  // Default number of row-buffer cells.
  localparam int MAX_COLS_DEF = 256;

  // Configuration register indexes (one address bit).
  localparam logic REG_TARGET_ROW = 1'b0;
  localparam logic REG_TARGET_COL = 1'b1;

  // Largest representable path sum.
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Request that pushes one new best sum into the row buffer.
  typedef struct packed {
    logic             push;
    logic [SUM_W-1:0] sum;
  } gmcp_wr_req_t;

endpackage

@@ sv/gmcp_cell.sv @@
// ----------------------------------------------------------------------------
// gmcp_cell: one stage of the row-buffer chain
// Holds one best sum. On a push it either loads the new sum (when it is the
// insertion cell) or takes the value of its upstream neighbor.
// ----------------------------------------------------------------------------
module gmcp_cell
  import gmcp_pkg::*;
(
  input  logic             clk,
  input  gmcp_wr_req_t     wr_req,
  input  logic             ins_sel,
  input  logic [SUM_W-1:0] up_sum,
  output logic [SUM_W-1:0] cell_sum
);

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;

  // Pick the new sum at the insertion point, otherwise shift from upstream.
  always_comb begin
    sum_nxt = ins_sel ? wr_req.sum : up_sum;
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (wr_req.push) begin
      sum_r <= sum_nxt;
    end
  end

  assign cell_sum = sum_r;

endmodule

@@ sv/gmcp_row_chain.sv @@
// ----------------------------------------------------------------------------
// gmcp_row_chain: row buffer built as a chain of cells
// New sums enter at a cell chosen from the row length and march toward the
// last cell, so the sum of the cell above leaves the chain exactly one row
// later. Rows longer than the chain are held to the full chain length.
// ----------------------------------------------------------------------------
module gmcp_row_chain
  import gmcp_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF
)(
  input  logic             clk,
  input  gmcp_wr_req_t     wr_req,
  input  logic [POS_W-1:0] target_col,
  output logic [SUM_W-1:0] above_sum
);

  localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LIM_W  = (CIDX_W > POS_W) ? CIDX_W : POS_W;
  localparam logic [LIM_W-1:0] LAST_CELL = LIM_W'(MAX_COLS - 1);

  logic [LIM_W-1:0]  tcol_ext;
  logic [CIDX_W-1:0] ins_pos;
  logic [SUM_W-1:0]  chain_sum [MAX_COLS];

  // Insertion cell: the row length counted back from the end of the chain.
  always_comb begin
    tcol_ext = LIM_W'(target_col);
    if (tcol_ext >= LAST_CELL) begin
      ins_pos = '0;
    end else begin
      ins_pos = CIDX_W'(LAST_CELL - tcol_ext);
    end
  end

  // The row of cells; the first cell takes the new sum from both sides.
  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    logic [SUM_W-1:0] up_sum;
    if (k == 0) begin : g_head
      assign up_sum = wr_req.sum;
    end else begin : g_body
      assign up_sum = chain_sum[k-1];
    end
    gmcp_cell u_cell (
      .clk      (clk),
      .wr_req   (wr_req),
      .ins_sel  (ins_pos == CIDX_W'(k)),
      .up_sum   (up_sum),
      .cell_sum (chain_sum[k])
    );
  end

  // The last cell holds the sum of the cell directly above.
  assign above_sum = chain_sum[MAX_COLS-1];

endmodule

@@ sv/grid_min_cost_path_core.sv @@
// ----------------------------------------------------------------------------
// grid_min_cost_path_core: least path cost through a streamed cost grid
// Cells arrive in row-major order; each best sum is the smaller of the sums
// above and to the left plus the cell cost. One result follows the last cell.
//
//  Port group | Direction | Carries
//  in_*       | sink      | one grid cell cost per request
//  out_*      | source    | least path cost after the destination cell
//  cfg_*      | APB slave | target_row (0x0), target_col (0x4)
//
// One cell is taken every cycle unless the input stalls; the limit is the left-sum loop, one compare
// and one add per cell against the row-buffer output.
// A result appears on out_* the cycle after the last cell is taken.
// Reset is synchronous; the row buffer needs no clearing pass.
// Input stalls only while a result waits and out_tready is low.
// Any register write restarts the sweep at the grid origin.
// ----------------------------------------------------------------------------
module grid_min_cost_path_core
  import gmcp_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  // Cell stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] cell_cost
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [24:0] min_cost, [31:25] zero
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [POS_W-1:0] target_row_r;
  logic [POS_W-1:0] target_col_r;
  logic [POS_W-1:0] row_pos_r;
  logic [POS_W-1:0] row_pos_nxt;
  logic [POS_W-1:0] col_pos_r;
  logic [POS_W-1:0] col_pos_nxt;
  logic [SUM_W-1:0] left_sum_r;
  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;

  logic             cfg_wr;
  logic             in_acc;
  logic             last_col;
  logic             last_cell;
  logic [SUM_W-1:0] above_sum;
  logic [SUM_W-1:0] best;
  logic [SUM_W:0]   raw_sum;
  logic [SUM_W-1:0] cell_sum;
  gmcp_wr_req_t     wr_req;

  // Configuration handshake and read-back.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      REG_TARGET_ROW: cfg_prdata = 32'(target_row_r);
      REG_TARGET_COL: cfg_prdata = 32'(target_col_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Input is taken whenever the result register is free or being drained.
  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;

  // Best predecessor sum and saturating add of the cell cost.
  always_comb begin
    if (row_pos_r == '0 && col_pos_r == '0) begin
      best = '0;
    end else if (row_pos_r == '0) begin
      best = left_sum_r;
    end else if (col_pos_r == '0) begin
      best = above_sum;
    end else begin
      best = (above_sum < left_sum_r) ? above_sum : left_sum_r;
    end
    raw_sum  = {1'b0, best} + (SUM_W+1)'(in_tdata);
    cell_sum = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];
  end

  // Grid position update.
  always_comb begin
    last_col    = (col_pos_r >= target_col_r);
    last_cell   = last_col & (row_pos_r >= target_row_r);
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r + 1'b1;
    if (last_col) begin
      col_pos_nxt = '0;
      row_pos_nxt = last_cell ? '0 : row_pos_r + 1'b1;
    end
  end

  // Row buffer push request.
  assign wr_req.push = in_acc;
  assign wr_req.sum  = cell_sum;

  gmcp_row_chain #(
    .MAX_COLS (MAX_COLS)
  ) u_row_chain (
    .clk        (clk),
    .wr_req     (wr_req),
    .target_col (target_col_r),
    .above_sum  (above_sum)
  );

  // Control state: targets, sweep position and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_row_r <= '0;
      target_col_r <= '0;
      row_pos_r    <= '0;
      col_pos_r    <= '0;
      left_sum_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[2])
          REG_TARGET_ROW: target_row_r <= cfg_pwdata[POS_W-1:0];
          REG_TARGET_COL: target_col_r <= cfg_pwdata[POS_W-1:0];
          default:        target_row_r <= target_row_r;
        endcase
        row_pos_r  <= '0;
        col_pos_r  <= '0;
        left_sum_r <= '0;
      end else if (in_acc) begin
        row_pos_r  <= row_pos_nxt;
        col_pos_r  <= col_pos_nxt;
        left_sum_r <= last_cell ? '0 : cell_sum;
      end
      if (in_acc && last_cell) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_acc && last_cell) begin
      out_sum_r <= cell_sum;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 32'(out_sum_r);

  // The input only stalls behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r)
    else $error("input stalled with no result pending");

  // The last cell of a grid always produces a result next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last_cell) |=> out_valid_r)
    else $error("final cell taken but no result raised");

  // The sweep never runs past the destination column or row.
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_pos_r <= target_col_r)
    else $error("column position beyond target column");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_pos_r <= target_row_r)
    else $error("row position beyond target row");

endmodule
